### sv/uuid7_pkg.sv
package uuid7_pkg;

    localparam int unsigned MS_W      = 50;
    localparam int unsigned TIME_W    = 48;
    localparam int unsigned RAND_A_W  = 12;
    localparam int unsigned RAND_B_W  = 62;
    localparam int unsigned HALF_W    = 64;
    localparam int unsigned STATUS_W  = 2;

    localparam logic [RAND_A_W-1:0] COUNTER_FULL = 12'hFFF;
    localparam logic [TIME_W-1:0]   TIME_MAX     = {TIME_W{1'b1}};
    localparam logic [3:0]          VERSION_NIB  = 4'h7;
    localparam logic [1:0]          VARIANT_BITS = 2'b10;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_TOO_LARGE = 2'd1,
        ST_EXHAUSTED = 2'd2
    } status_t;

    typedef struct packed {
        logic                 mode;
        logic [RAND_B_W-1:0]  rand_b;
        logic [RAND_A_W-1:0]  rand_a;
        logic [MS_W-1:0]      unix_ms;
    } item_t;

    typedef struct packed {
        status_t              status;
        logic [HALF_W-1:0]    uuid_low;
        logic [HALF_W-1:0]    uuid_high;
    } result_t;

endpackage

### sv/uuid7_calc.sv
module uuid7_calc
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              advance,
    input  uuid7_pkg::item_t  item,
    output uuid7_pkg::result_t result
);
    import uuid7_pkg::*;

    logic                seen_reg, seen_next;
    logic [TIME_W-1:0]   last_time_reg, last_time_next;
    logic [RAND_A_W-1:0] last_counter_reg, last_counter_next;

    logic                neg;
    logic                too_large;
    logic                exhausted;
    logic [TIME_W-1:0]   t_in;
    logic [TIME_W-1:0]   t_out;
    logic [RAND_A_W-1:0] field;
    logic                state_wr;

    always_comb
    begin
        neg       = item.unix_ms[MS_W-1];
        too_large = !neg && item.unix_ms[MS_W-2];
        t_in      = neg ? '0 : item.unix_ms[TIME_W-1:0];
        t_out     = t_in;
        field     = item.rand_a;
        exhausted = 1'b0;

        // never run backward: a time not past the last reuses or bumps it
        if (item.mode && seen_reg && t_in <= last_time_reg)
        begin
            if (last_counter_reg == COUNTER_FULL)
            begin
                if (last_time_reg == TIME_MAX)
                    exhausted = 1'b1;
                t_out = last_time_reg + 1'b1;
            end
            else
            begin
                t_out = last_time_reg;
                field = last_counter_reg + 1'b1;
            end
        end

        if (too_large)
        begin
            result.status    = ST_TOO_LARGE;
            result.uuid_high = '0;
            result.uuid_low  = '0;
        end
        else if (exhausted)
        begin
            result.status    = ST_EXHAUSTED;
            result.uuid_high = '0;
            result.uuid_low  = '0;
        end
        else
        begin
            result.status    = ST_OK;
            result.uuid_high = {t_out, VERSION_NIB, field};
            result.uuid_low  = {VARIANT_BITS, item.rand_b};
        end

        state_wr          = advance && item.mode && !too_large && !exhausted;
        seen_next         = state_wr ? 1'b1  : seen_reg;
        last_time_next    = state_wr ? t_out : last_time_reg;
        last_counter_next = state_wr ? field : last_counter_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg         <= 1'b0;
            last_time_reg    <= '0;
            last_counter_reg <= '0;
        end
        else
        begin
            seen_reg         <= seen_next;
            last_time_reg    <= last_time_next;
            last_counter_reg <= last_counter_next;
        end
    end

    a_time_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        state_wr |=> last_time_reg >= $past(last_time_reg))
        else $error("kept time ran backward");

    a_hold_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && (too_large || exhausted)) |=>
            $stable(last_time_reg) && $stable(last_counter_reg) && $stable(seen_reg))
        else $error("state changed on an error transaction");

    a_id_increases: assert property (@(posedge clk) disable iff (!rst_n)
        (state_wr && $past(state_wr)) |->
            {t_out, field} > {$past(t_out), $past(field)} || !seen_reg)
        else $error("monotonic identifier did not increase");

endmodule

### sv/uuid_v7_monotonic_generator.sv
// UUID version 7 generator with a monotonic mode.
// Input stream (s_axis_*): one request per transaction, tdata carries the
// signed millisecond time and both random fields, tuser the mode bit.
// Output stream (m_axis_*): one identifier per request, tdata holds the two
// 64-bit halves, tuser the status (ok, time too large, range exhausted).
// On an error both halves are zero and the kept state is left as it was.
// The request is captured in an input register, the identifier is formed by
// one pass of compare/increment/packing logic and held in a result register.
// While the receiver does not stall, a new request is taken every cycle.
// The kept time and 12-bit counter are updated as a request moves into the
// result register, so back-to-back monotonic requests see each other's state.
// Reset clears the kept state (nothing seen yet) and empties both registers.
// When the receiver stalls, the result register holds, the input register
// fills, and s_axis_tready drops until the result is taken.
module uuid_v7_monotonic_generator
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // [49:0] unix_ms, [61:50] rand_a, [123:62] rand_b, [127:124] zero
    input  logic [127:0] s_axis_tdata,
    // [0] mode
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [63:0] uuid_high, [127:64] uuid_low
    output logic [127:0] m_axis_tdata,
    // [1:0] status
    output logic [1:0]   m_axis_tuser
);
    import uuid7_pkg::*;

    logic    in_valid_reg, in_valid_next;
    item_t   in_item_reg, in_item_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    result_t calc_res;
    logic    advance;

    uuid7_calc u_calc
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .item    (in_item_reg),
        .result  (calc_res)
    );

    always_comb
    begin
        advance        = in_valid_reg && (!out_valid_reg || m_axis_tready);
        s_axis_tready  = !in_valid_reg || advance;

        in_valid_next  = in_valid_reg;
        in_item_next   = in_item_reg;
        if (s_axis_tready)
        begin
            in_valid_next = s_axis_tvalid;
            in_item_next  = {s_axis_tuser, s_axis_tdata[123:0]};
        end

        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (!out_valid_reg || m_axis_tready)
        begin
            out_valid_next = in_valid_reg;
            out_next       = calc_res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
        out_reg     <= out_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_reg.uuid_low, out_reg.uuid_high};
    assign m_axis_tuser  = out_reg.status;

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser != 2'd3)
        else $error("undefined status code");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> m_axis_tdata == '0)
        else $error("error transaction carries a nonzero identifier");

    a_ok_marks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |->
            m_axis_tdata[15:12] == VERSION_NIB && m_axis_tdata[127:126] == VARIANT_BITS)
        else $error("version or variant bits missing");

    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !m_axis_tready) |=> in_valid_reg)
        else $error("pending request lost during stall");

endmodule
